// ===== sv/q31pid_pkg.sv =====
// ----------------------------------------------------------------------------
// q31pid_pkg
// Shared types, register codes and Q31 saturating arithmetic for the PID unit.
// ----------------------------------------------------------------------------
package q31pid_pkg;

  localparam int GAIN_CNT  = 3;
  localparam int GAIN_P    = 0;
  localparam int GAIN_I    = 1;
  localparam int GAIN_D    = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [31:0] Q31_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_FRAC   = 3'd0,
    REG_PROP_SHIFT  = 3'd1,
    REG_INTEG_FRAC  = 3'd2,
    REG_INTEG_SHIFT = 3'd3,
    REG_DERIV_FRAC  = 3'd4,
    REG_DERIV_SHIFT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] frac;
    logic signed [5:0]  shift;
  } gain_t;

  typedef gain_t [GAIN_CNT-1:0] gain_set_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] res;
    if (v[32] != v[31]) begin
      res = v[32] ? Q31_MIN : Q31_MAX;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // Applies 2^(shift+1) to the high half of the gain product.
  function automatic logic signed [31:0] scale_shift(input logic signed [31:0] p,
                                                     input logic signed [5:0]  s);
    logic signed [6:0]  k;
    logic signed [64:0] wide;
    logic [5:0]         rsh;
    logic [33:0]        hi;
    logic signed [31:0] res;
    k    = $signed({s[5], s}) + 7'sd1;
    wide = $signed({{33{p[31]}}, p}) <<< k[5:0];
    rsh  = (~k[5:0]) + 6'd1;
    hi   = wide[64:31];
    if (!k[6]) begin
      if ((&hi) || !(|hi)) begin
        res = wide[31:0];
      end else begin
        res = wide[64] ? Q31_MIN : Q31_MAX;
      end
    end else begin
      res = p >>> rsh;
    end
    return res;
  endfunction

endpackage

// ===== sv/q31pid_cfg.sv =====
// ----------------------------------------------------------------------------
// q31pid_cfg
// Gain register file: fraction and shift for each of the three terms.
// ----------------------------------------------------------------------------
module q31pid_cfg import q31pid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data,
  output gain_set_t            gains
);

  gain_set_t gains_r, gains_nxt;

  always_comb begin
    gains_nxt = gains_r;
    if (wr_en) begin
      case (wr_index)
        REG_PROP_FRAC:   gains_nxt[GAIN_P].frac  = wr_data;
        REG_PROP_SHIFT:  gains_nxt[GAIN_P].shift = wr_data[5:0];
        REG_INTEG_FRAC:  gains_nxt[GAIN_I].frac  = wr_data;
        REG_INTEG_SHIFT: gains_nxt[GAIN_I].shift = wr_data[5:0];
        REG_DERIV_FRAC:  gains_nxt[GAIN_D].frac  = wr_data;
        REG_DERIV_SHIFT: gains_nxt[GAIN_D].shift = wr_data[5:0];
        default:         gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  assign gains = gains_r;

endmodule

// ===== sv/q31pid_scale.sv =====
// ----------------------------------------------------------------------------
// q31pid_scale
// Two-stage gain unit: registered 32x32 product high half, then registered
// power-of-two shift with Q31 saturation.
// ----------------------------------------------------------------------------
module q31pid_scale import q31pid_pkg::*; (
  input  logic               clk,
  input  logic               en_mul,
  input  logic               en_shf,
  input  logic signed [31:0] x,
  input  gain_t              gain,
  output logic signed [31:0] y
);

  logic signed [63:0] prod;
  logic signed [31:0] prod_r;
  logic signed [5:0]  shift_r;
  logic signed [31:0] y_r;

  assign prod = x * gain.frac;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r  <= prod[63:32];
      shift_r <= gain.shift;
    end
    if (en_shf) begin
      y_r <= scale_shift(prod_r, shift_r);
    end
  end

  assign y = y_r;

endmodule

// ===== sv/q31_pid_controller_unit.sv =====
// ----------------------------------------------------------------------------
// q31_pid_controller_unit
// Q31 PID controller: saturating error, integral accumulator and derivative
// of the error, three scaled gains, saturated drive output.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------
//  input   | in_tvalid  in_tready  in_tdata | [31:0] target_value,
//          |                                | [63:32] measured_value
//  output  | out_tvalid out_tready out_tdata| [31:0] drive
//  config  | cfg_valid  cfg_ready           | cfg_index (register), cfg_data
//
//  One transfer per cycle sustained while out_tready stays high; seven stage
//  registers from input to output. The integral accumulator updates in a
//  single stage, one add per sample. Each stage holds its item while the
//  next stage cannot accept it; bubbles close up.
//  Synchronous active-low reset clears stage valids, gains, integral and
//  last error. cfg_ready is always high.
// ----------------------------------------------------------------------------
module q31_pid_controller_unit import q31pid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // target_value, measured_value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // drive
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NSTG = 7;

  gain_set_t gains;

  logic [NSTG-1:0] v_r, v_nxt, rdy, en;

  logic signed [31:0] sp_r, pv_r;
  logic signed [31:0] err_c, diff_c;
  logic signed [31:0] err1_r, diff1_r;
  logic signed [31:0] prev_err_r;
  logic signed [31:0] t_p, t_i, t_d;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [31:0] tp4_r, td4_r;
  logic signed [31:0] a5_r, td5_r;
  logic signed [31:0] drive_r;

  assign cfg_ready = 1'b1;

  q31pid_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .gains    (gains)
  );

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    en[0] = rdy[0] && in_tvalid;
    for (int i = 1; i < NSTG; i++) begin
      en[i] = rdy[i] && v_r[i-1];
    end
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = drive_r;

  assign err_c  = sat_sub(sp_r, pv_r);
  assign diff_c = sat_sub(err_c, prev_err_r);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sp_r <= in_tdata[31:0];
      pv_r <= in_tdata[63:32];
    end
    if (en[1]) begin
      err1_r  <= err_c;
      diff1_r <= diff_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (en[1]) begin
      prev_err_r <= err_c;
    end
  end

  q31pid_scale u_scale_p (
    .clk    (clk),
    .en_mul (en[2]),
    .en_shf (en[3]),
    .x      (err1_r),
    .gain   (gains[GAIN_P]),
    .y      (t_p)
  );

  q31pid_scale u_scale_i (
    .clk    (clk),
    .en_mul (en[2]),
    .en_shf (en[3]),
    .x      (err1_r),
    .gain   (gains[GAIN_I]),
    .y      (t_i)
  );

  q31pid_scale u_scale_d (
    .clk    (clk),
    .en_mul (en[2]),
    .en_shf (en[3]),
    .x      (diff1_r),
    .gain   (gains[GAIN_D]),
    .y      (t_d)
  );

  assign integ_nxt = sat_add(t_i, integ_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (en[4]) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tp4_r <= t_p;
      td4_r <= t_d;
    end
    if (en[5]) begin
      a5_r  <= sat_add(tp4_r, integ_r);
      td5_r <= td4_r;
    end
    if (en[6]) begin
      drive_r <= sat_add(a5_r, td5_r);
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> v_r == '0)
    else $error("stage valids not cleared by reset");

  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    en[1] |=> prev_err_r == err1_r)
    else $error("last error does not track stage one error");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en[4] |=> $stable(integ_r))
    else $error("integral changed without a stage four transfer");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && !rdy[5] |=> v_r[5] && $stable(a5_r))
    else $error("stalled stage lost its item");
`endif

endmodule
